@@ hw/rtl/tty_line_read_assembler_defines.svh @@
// Assertion macros for the tty line read assembler.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TTY_LINE_READ_ASSEMBLER_DEFINES_SVH
`define TTY_LINE_READ_ASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
`define TTYLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TTYLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTYLA_ASSERT_IMP(lbl, ante, cons, msg)
`define TTYLA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/ttyla_pkg.sv @@
// Shared types and constants for the tty line read assembler.
// No dependencies.
`timescale 1ns / 1ps

package ttyla_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RX      = 1'b1;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [2:0] {
    KIND_ACCEPT = 3'd0,
    KIND_BUSY   = 3'd1,
    KIND_ECHO   = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ECHO_ITEM = 2'd0,
    ECHO_BS   = 2'd1,
    ECHO_SP   = 2'd2
  } echo_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BUSY,
    ST_ACCEPT,
    ST_ERASE1,
    ST_ERASE2,
    ST_ERASE3,
    ST_ECHO,
    ST_FINISH,
    ST_STREAM,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      accept_upd;
    logic      bs_dec;
    logic      store;
    logic      idx_clr;
    logic      adv;
    logic      release_rd;
    logic      load;
    kind_t     kind;
    echo_sel_t echo_sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic pending;
    logic is_bs;
    logic fill_zero;
    logic can_store;
    logic complete;
    logic stream_last;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/ttyla_ctrl.sv @@
// Controller state machine of the tty line read assembler.
// Depends on ttyla_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module ttyla_ctrl
  import ttyla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.accept_upd = 1'b0;
    cmd.bs_dec     = 1'b0;
    cmd.store      = 1'b0;
    cmd.idx_clr    = 1'b0;
    cmd.adv        = 1'b0;
    cmd.release_rd = 1'b0;
    cmd.load       = 1'b0;
    cmd.kind       = KIND_ACCEPT;
    cmd.echo_sel   = ECHO_ITEM;
    cmd.last       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.op == OP_REQUEST) begin
          if (sts.pending) begin
            state_nxt = ST_BUSY;
          end else begin
            cmd.accept_upd = 1'b1;
            state_nxt      = ST_ACCEPT;
          end
        end else if (!sts.pending) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_bs) begin
          if (!sts.fill_zero) begin
            cmd.bs_dec = 1'b1;
            state_nxt  = ST_ERASE1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (sts.can_store) begin
          cmd.store = 1'b1;
          state_nxt = ST_ECHO;
        end else if (sts.complete) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BUSY, ST_ACCEPT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.kind  = (state_r == ST_BUSY) ? KIND_BUSY : KIND_ACCEPT;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERASE1: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_ECHO;
          cmd.echo_sel = ECHO_BS;
          state_nxt    = ST_ERASE2;
        end
      end
      ST_ERASE2: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_ECHO;
          cmd.echo_sel = ECHO_SP;
          state_nxt    = ST_ERASE3;
        end
      end
      ST_ERASE3: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_ECHO;
          cmd.echo_sel = ECHO_BS;
          cmd.last     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_ECHO;
          cmd.echo_sel = ECHO_ITEM;
          cmd.last     = !sts.complete;
          state_nxt    = sts.complete ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.fill_zero ? ST_EMPTY : ST_STREAM;
      end
      ST_STREAM: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.kind = KIND_DATA;
          cmd.last = sts.stream_last;
          cmd.adv  = 1'b1;
          if (sts.stream_last) begin
            cmd.release_rd = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.load       = 1'b1;
          cmd.kind       = KIND_EMPTY;
          cmd.last       = 1'b1;
          cmd.release_rd = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ttyla_datapath.sv @@
// Datapath of the tty line read assembler: item capture, line memory,
// read state registers and the result register. Depends on ttyla_pkg.
`timescale 1ns / 1ps

module ttyla_datapath
  import ttyla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_operation,
  input  logic [15:0] in_request_length,
  input  logic [15:0] in_requester_id,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_reply_to,
  output logic [5:0]  out_read_count,
  output logic        out_last,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [7:0] line_mem [BUFFER_DEPTH];

  logic             item_op_r;
  logic [15:0]      item_len_r;
  logic [15:0]      item_who_r;
  logic [7:0]       item_byte_r;
  logic             item_bs_r;

  logic             pending_r, pending_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] wanted_r, wanted_nxt;
  logic [15:0]      req_r, req_nxt;

  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]       rd_data_r;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r;
  logic [7:0]       out_byte_r;
  logic [15:0]      out_reply_r;
  logic [5:0]       out_count_r;
  logic             out_last_r;

  logic             is_eot;
  logic [CNT_W-1:0] clamp_len;
  logic [7:0]       echo_byte;
  logic [7:0]       ld_byte;
  logic [15:0]      ld_reply;
  logic [5:0]       ld_count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op_r   <= in_operation;
      item_len_r  <= in_request_length;
      item_who_r  <= in_requester_id;
      item_byte_r <= (in_rx_byte == CH_CR) ? CH_LF : in_rx_byte;
      item_bs_r   <= (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
    end
  end

  assign is_eot    = (item_byte_r == CH_EOT);
  assign clamp_len = ((item_len_r == 16'd0) || (item_len_r > 16'(BUFFER_DEPTH)))
                   ? CNT_W'(BUFFER_DEPTH) : item_len_r[CNT_W-1:0];

  always_comb begin
    pending_nxt = pending_r;
    fill_nxt    = fill_r;
    wanted_nxt  = wanted_r;
    req_nxt     = req_r;
    priority if (cmd.release_rd) begin
      pending_nxt = 1'b0;
      fill_nxt    = '0;
      wanted_nxt  = '0;
      req_nxt     = '0;
    end else if (cmd.accept_upd) begin
      pending_nxt = 1'b1;
      fill_nxt    = '0;
      wanted_nxt  = clamp_len;
      req_nxt     = item_who_r;
    end else if (cmd.bs_dec) begin
      fill_nxt = fill_r - CNT_W'(1);
    end else if (cmd.store) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      fill_r    <= '0;
      wanted_r  <= '0;
      req_r     <= '0;
    end else begin
      pending_r <= pending_nxt;
      fill_r    <= fill_nxt;
      wanted_r  <= wanted_nxt;
      req_r     <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_mem[fill_r[IDX_W-1:0]] <= item_byte_r;
    end
  end

  always_comb begin
    priority if (cmd.idx_clr) begin
      rd_idx_nxt = '0;
    end else if (cmd.adv) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end else begin
      rd_idx_nxt = rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    rd_data_r <= line_mem[rd_idx_nxt];
  end

  always_comb begin
    unique case (cmd.echo_sel)
      ECHO_ITEM: echo_byte = item_byte_r;
      ECHO_BS:   echo_byte = CH_BS;
      ECHO_SP:   echo_byte = CH_SP;
      default:   echo_byte = item_byte_r;
    endcase
  end

  always_comb begin
    ld_byte  = '0;
    ld_reply = '0;
    ld_count = '0;
    unique case (cmd.kind)
      KIND_ACCEPT, KIND_BUSY: begin
        ld_reply = item_who_r;
      end
      KIND_ECHO: begin
        ld_byte = echo_byte;
      end
      KIND_DATA: begin
        ld_byte  = rd_data_r;
        ld_reply = req_r;
        ld_count = 6'(fill_r);
      end
      KIND_EMPTY: begin
        ld_reply = req_r;
      end
      default: begin
        ld_byte = '0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind_r  <= cmd.kind;
      out_byte_r  <= ld_byte;
      out_reply_r <= ld_reply;
      out_count_r <= ld_count;
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_byte_value = out_byte_r;
  assign out_reply_to   = out_reply_r;
  assign out_read_count = out_count_r;
  assign out_last       = out_last_r;

  assign sts.op          = item_op_r;
  assign sts.pending     = pending_r;
  assign sts.is_bs       = item_bs_r;
  assign sts.fill_zero   = (fill_r == '0);
  assign sts.can_store   = !is_eot && (fill_r < CNT_W'(BUFFER_DEPTH));
  assign sts.complete    = (fill_r >= wanted_r) || (item_byte_r == CH_LF) || is_eot;
  assign sts.stream_last = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_r);
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

@@ hw/rtl/tty_line_read_assembler.sv @@
// Top level of the tty line read assembler: controller plus datapath.
// Depends on ttyla_pkg, ttyla_ctrl, ttyla_datapath and the defines header.
//
// The block takes one item at a time: in_ready is high only while it is idle.
// A read request gets an accept or busy reply; an ordinary byte is echoed, and
// an erase sends three echoes. A completing byte then streams the buffered line,
// or sends an empty reply if the line is empty, at one byte per cycle while
// out_ready is high, from the registered read port of the 32-entry line memory.
// Results sit in an output register; while out_ready is low it holds its result
// and the controller waits.
`timescale 1ns / 1ps
`include "tty_line_read_assembler_defines.svh"

module tty_line_read_assembler
  import ttyla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_request_length,
  input  logic [15:0] in_requester_id,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_reply_to,
  output logic [5:0]  out_read_count,
  output logic        out_last
);

  cmd_t cmd;
  sts_t sts;

  ttyla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttyla_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_request_length (in_request_length),
    .in_requester_id   (in_requester_id),
    .in_rx_byte        (in_rx_byte),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_byte_value    (out_byte_value),
    .out_reply_to      (out_reply_to),
    .out_read_count    (out_read_count),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

  `TTYLA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                    "input taken while busy")
  `TTYLA_ASSERT_IMP(a_data_count, out_valid && (out_kind == KIND_DATA),
                    out_read_count != 6'd0, "data transaction with zero count")
  `TTYLA_ASSERT_IMP(a_echo_fields, out_valid && (out_kind == KIND_ECHO),
                    (out_reply_to == 16'd0) && (out_read_count == 6'd0),
                    "echo transaction carries completion fields")
  `TTYLA_ASSERT_IMP(a_load_when_free, cmd.load, !out_valid || out_ready,
                    "result register overwritten")

endmodule

@@ bench/tty_line_read_assembler_tb.sv @@
// Self-checking bench for tty_line_read_assembler: valid/ready drivers, random stalls
// and a scoreboard class that predicts line editing, echoes and read completions.
// Depends on ttyla_pkg and the tty_line_read_assembler RTL.
`timescale 1ns / 1ps

module tty_line_read_assembler_tb
  import ttyla_pkg::*;
();

  localparam int ITEM_TARGET = 380;
  localparam int CALM_FROM   = 320;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [15:0] reply_to;
    logic [5:0]  read_count;
    logic        last;
  } tty_reply_t;

  class line_read_scoreboard;
    logic [7:0]  line_mem [BUFFER_DEPTH];
    int unsigned fill;
    int unsigned wanted;
    bit          pending;
    logic [15:0] owner;
    tty_reply_t  expected_replies [$];
    int          errors;
    int          replies_seen;
    int          lines_streamed;
    int          empty_reads;
    int          busy_replies;
    int          erases;

    function new();
      fill = 0;
      wanted = 0;
      pending = 0;
      owner = '0;
      errors = 0;
      replies_seen = 0;
      lines_streamed = 0;
      empty_reads = 0;
      busy_replies = 0;
      erases = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    function void add_reply(kind_t k, logic [7:0] b, logic [15:0] who, logic [5:0] cnt);
      tty_reply_t r;
      r.kind = k;
      r.byte_value = b;
      r.reply_to = who;
      r.read_count = cnt;
      r.last = 1'b0;
      expected_replies.push_back(r);
    endfunction

    // Returns how many replies the accepted transaction causes.
    function int predict_line_edit(logic op, logic [15:0] len, logic [15:0] id,
                                   logic [7:0] rx);
      int         before_cnt;
      logic [7:0] b;
      bit         eot;
      tty_reply_t tail;
      before_cnt = expected_replies.size();
      b = rx;
      eot = 0;
      if (op == OP_REQUEST) begin
        if (pending) begin
          add_reply(KIND_BUSY, 8'h00, id, 6'd0);
          busy_replies++;
        end else begin
          pending = 1;
          fill = 0;
          wanted = (len == 16'd0 || len > BUFFER_DEPTH) ? BUFFER_DEPTH : len;
          owner = id;
          add_reply(KIND_ACCEPT, 8'h00, id, 6'd0);
        end
      end else if (pending) begin
        if (b == CH_BS || b == CH_DEL) begin
          if (fill > 0) begin
            fill--;
            add_reply(KIND_ECHO, CH_BS, 16'd0, 6'd0);
            add_reply(KIND_ECHO, CH_SP, 16'd0, 6'd0);
            add_reply(KIND_ECHO, CH_BS, 16'd0, 6'd0);
            erases++;
          end
        end else begin
          if (b == CH_CR) b = CH_LF;
          if (b == CH_EOT) begin
            eot = 1;
          end else if (fill < BUFFER_DEPTH) begin
            line_mem[fill] = b;
            fill++;
            add_reply(KIND_ECHO, b, 16'd0, 6'd0);
          end
          if (fill >= wanted || b == CH_LF || eot) begin
            if (fill == 0) begin
              add_reply(KIND_EMPTY, 8'h00, owner, 6'd0);
              empty_reads++;
            end else begin
              for (int i = 0; i < fill; i++)
                add_reply(KIND_DATA, line_mem[i], owner, 6'(fill));
              lines_streamed++;
            end
            pending = 0;
            fill = 0;
            wanted = 0;
            owner = '0;
          end
        end
      end
      if (expected_replies.size() > before_cnt) begin
        tail = expected_replies.pop_back();
        tail.last = 1'b1;
        expected_replies.push_back(tail);
      end
      return expected_replies.size() - before_cnt;
    endfunction

    function void check_reply(logic [2:0] kind, logic [7:0] bv, logic [15:0] who,
                              logic [5:0] cnt, logic lst);
      tty_reply_t e;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: kind %0d byte_value 'h%02h reply_to 'h%04h", kind, bv, who);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (e.kind !== kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (e.byte_value !== bv) begin
        $error("byte_value: expected 'h%02h, actual 'h%02h", e.byte_value, bv);
        errors++;
      end
      if (e.reply_to !== who) begin
        $error("reply_to: expected 'h%04h, actual 'h%04h", e.reply_to, who);
        errors++;
      end
      if (e.read_count !== cnt) begin
        $error("read_count: expected %0d, actual %0d", e.read_count, cnt);
        errors++;
      end
      if (e.last !== lst) begin
        $error("last: expected %0b, actual %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_REQUEST;
  logic [15:0] in_request_length = '0;
  logic [15:0] in_requester_id = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [15:0] out_reply_to;
  logic [5:0]  out_read_count;
  logic        out_last;

  line_read_scoreboard sb = new();
  bit tx_idle_en = 1;
  bit rx_idle_en = 1;
  int useful_items = 0;
  int cycle_count = 0;

  tty_line_read_assembler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_request_length (in_request_length),
    .in_requester_id   (in_requester_id),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte_value    (out_byte_value),
    .out_reply_to      (out_reply_to),
    .out_read_count    (out_read_count),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tty_line_read_assembler_tb failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply(out_kind, out_byte_value, out_reply_to, out_read_count, out_last);
  end

  task automatic send_item(logic op, logic [15:0] len, logic [15:0] id, logic [7:0] rx);
    int n;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_length <= len;
    in_requester_id <= id;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    n = sb.predict_line_edit(op, len, id, rx);
    if (n > 0) useful_items++;
  endtask

  task automatic send_request(logic [15:0] len, logic [15:0] id);
    send_item(OP_REQUEST, len, id, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_RX, 16'($urandom), 16'($urandom), b);
  endtask

  // Hold the sender off until every outstanding reply has arrived.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_line();
    logic [15:0] len;
    logic [7:0]  b;
    int          pick;
    int          guard;
    bit          long_line;
    long_line = 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) len = 16'($urandom_range(1, 8));
    else if (pick < 80) len = 16'($urandom_range(9, BUFFER_DEPTH));
    else if (pick < 88) len = 16'd0;
    else if (pick < 94) begin
      len = 16'd0;
      long_line = 1;
    end else len = 16'($urandom);
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
    send_request(len, 16'($urandom));
    guard = 0;
    while (sb.pending && guard < 80) begin
      pick = $urandom_range(0, 99);
      if (long_line) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      else if (pick < 72) begin
        if (pick < 55) b = 8'($urandom_range(8'h20, 8'h7e));
        else if (pick < 60) b = CH_BS;
        else if (pick < 65) b = CH_DEL;
        else if (pick < 67) b = CH_CR;
        else if (pick < 69) b = CH_LF;
        else b = CH_EOT;
        send_byte(b);
      end else if (pick < 75) send_request(16'($urandom), 16'($urandom));
      else send_byte(8'($urandom));
      guard++;
    end
    if (sb.pending) send_byte(CH_EOT);
  endtask

  initial begin
    bit paused;
    paused = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored byte, full-depth request, erase on empty, busy
    send_byte(8'h41);
    send_request(16'd0, 16'hffff);
    send_byte(CH_BS);
    send_request(16'd5, 16'h0000);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(CH_BS);
    send_byte(8'h78);
    send_byte(CH_DEL);
    send_byte(CH_CR);
    send_request(16'd1, 16'h1234);
    send_byte(8'h41);
    send_request(16'hffff, 16'h8000);
    send_byte(CH_EOT);
    send_request(16'd2, 16'h0001);
    send_byte(8'h61);
    send_byte(CH_EOT);
    send_request(16'd3, 16'h7fff);
    send_byte(CH_LF);
    send_request(16'd33, 16'h5a5a);
    send_byte(CH_EOT);
    drain_replies();

    while (useful_items < ITEM_TARGET) begin
      if (useful_items >= CALM_FROM) begin
        tx_idle_en = 0;
        rx_idle_en = 0;
      end else begin
        tx_idle_en = ($urandom_range(0, 4) != 0);
        rx_idle_en = ($urandom_range(0, 4) != 0);
      end
      if (!paused && useful_items >= ITEM_TARGET / 2) begin
        drain_replies();
        paused = 1;
      end
      random_line();
    end
    in_valid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transactions and %0d replies", useful_items, sb.replies_seen);
    $display("%0d lines streamed, %0d empty reads, %0d busy replies, %0d erases",
             sb.lines_streamed, sb.empty_reads, sb.busy_replies, sb.erases);
    if (sb.errors == 0) begin
      $display("tty_line_read_assembler_tb passed");
    end else begin
      $display("tty_line_read_assembler_tb failed");
    end
    $finish;
  end

endmodule

@@ tty_line_read_assembler.f @@
+incdir+hw/rtl
hw/rtl/ttyla_pkg.sv
hw/rtl/ttyla_ctrl.sv
hw/rtl/ttyla_datapath.sv
hw/rtl/tty_line_read_assembler.sv
bench/tty_line_read_assembler_tb.sv
